// ===== rtl/core/bfsp_pkg.sv =====
// Shared constants for the shortest-path engine.
package bfsp_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int WEIGHT_BITS_DEF  = 16;

  localparam int COUNT_W     = 7;
  localparam int IDX_W       = 6;
  localparam int WEIGHT_IN_W = 16;
  localparam int DIST_W      = 32;
  localparam int REG_IDX_W   = 1;

  localparam logic [REG_IDX_W-1:0] REG_VERTEX_COUNT  = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_SOURCE_VERTEX = 1'd1;

  localparam logic signed [DIST_W-1:0] DIST_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DIST_W-1:0] DIST_MIN = 32'sh8000_0000;

endpackage

// ===== rtl/core/bfsp_ram.sv =====
// Generic simple dual-port RAM with registered read.
module bfsp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/bellman_ford_shortest_paths.sv =====
// Top level: single-source shortest paths over a stored signed adjacency matrix.
//
//  channel   ports                                         beat taken when
//  -------   --------------------------------------------  -------------------
//  item      start busy kind row col weight                start && !busy
//  config    wr_en wr_index wr_data                        wr_en
//  result    strobe vertex distance reachable              strobe (no stall)
//            negative_cycle last
//
// A matrix write leaves busy low.
// A run relaxes one pair per cycle through the weight and distance memories
// (n-1 rounds plus a checking round), then streams n results, or a single
// negative-cycle beat.
// Reset is synchronous; the memories need no clearing pass.
// Results leave one per cycle; the receiver cannot stall them.
module bellman_ford_shortest_paths import bfsp_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic                     kind,
  input  logic [IDX_W-1:0]         row,
  input  logic [IDX_W-1:0]         col,
  input  logic signed [WEIGHT_IN_W-1:0] weight,
  input  logic                     wr_en,
  input  logic [REG_IDX_W-1:0]     wr_index,
  input  logic [COUNT_W-1:0]       wr_data,
  output logic                     strobe,
  output logic [IDX_W-1:0]         vertex,
  output logic signed [DIST_W-1:0] distance,
  output logic                     reachable,
  output logic                     negative_cycle,
  output logic                     last
);

  localparam int IW  = $clog2(MAX_VERTICES);
  localparam int CW  = $clog2(MAX_VERTICES + 1);
  localparam int WAW = $clog2(MAX_VERTICES * MAX_VERTICES);
  localparam int WX  = (WEIGHT_BITS > WEIGHT_IN_W) ? WEIGHT_BITS : WEIGHT_IN_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RELAX = 3'd1;
  localparam logic [2:0] S_FLUSH = 3'd2;
  localparam logic [2:0] S_OUT   = 3'd3;
  localparam logic [2:0] S_OLAST = 3'd4;

  logic [2:0]         state;
  logic [COUNT_W-1:0] vcount;
  logic [IDX_W-1:0]   src;
  logic [CW-1:0]      n_run;
  logic [CW-1:0]      rnd;
  logic [IW-1:0]      iu, iv, ok, oidx;
  logic               s2_valid, s2_check;
  logic [IW-1:0]      s2_u, s2_v;
  logic [MAX_VERTICES-1:0] reached;
  logic               wq_en;
  logic [IW-1:0]      wq_addr;
  logic signed [DIST_W-1:0] wq_data;
  logic               cyc;
  logic               ovalid;

  logic               accept, run_go, ld, src_in, check_issue, ld_ok;
  logic [COUNT_W-1:0] n_sel;
  logic [IW-1:0]      last_idx;
  logic [WX-1:0]      wz;
  logic [WAW-1:0]     w_waddr, w_raddr;
  logic [WEIGHT_BITS-1:0] w_dout;
  logic [IW-1:0]      da_raddr;
  logic [DIST_W-1:0]  da_dout, db_dout;
  logic               d_we;
  logic [IW-1:0]      d_waddr;
  logic [DIST_W-1:0]  d_wdata;

  logic signed [DIST_W-1:0] du, dv, cand;
  logic signed [DIST_W:0]   wext, sum;
  logic               edge_ok, relax, relax_w;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign run_go = accept && kind;
  assign ld     = accept && !kind;

  assign n_sel = (vcount == '0) ? COUNT_W'(1) :
                 (vcount > COUNT_W'(MAX_VERTICES)) ? COUNT_W'(MAX_VERTICES) : vcount;
  assign src_in      = {1'b0, src} < n_sel;
  assign last_idx    = IW'(n_run - CW'(1));
  assign check_issue = (rnd == n_run);

  assign ld_ok = ld && ({1'b0, row} < COUNT_W'(MAX_VERTICES))
                    && ({1'b0, col} < COUNT_W'(MAX_VERTICES));
  assign wz      = WX'($unsigned(weight));
  assign w_waddr = WAW'(WAW'(row) * WAW'(MAX_VERTICES) + WAW'(col));
  assign w_raddr = WAW'(WAW'(iu) * WAW'(MAX_VERTICES) + WAW'(iv));

  // relaxation of the pair whose reads came back this cycle
  assign du   = (wq_en && wq_addr == s2_u) ? wq_data : $signed(da_dout);
  assign dv   = (wq_en && wq_addr == s2_v) ? wq_data : $signed(db_dout);
  assign wext = (DIST_W+1)'($signed(w_dout));
  assign sum  = (DIST_W+1)'(du) + wext;
  assign cand = (sum[DIST_W] != sum[DIST_W-1]) ? (sum[DIST_W] ? DIST_MIN : DIST_MAX)
                                                : sum[DIST_W-1:0];
  assign edge_ok = (s2_u == s2_v) || (w_dout != '0);
  assign relax   = s2_valid && reached[s2_u] && edge_ok && (!reached[s2_v] || cand < dv);
  assign relax_w = relax && !s2_check;

  assign d_we     = relax_w || (run_go && src_in);
  assign d_waddr  = relax_w ? s2_v : IW'(src);
  assign d_wdata  = relax_w ? cand : '0;
  assign da_raddr = (state == S_OUT) ? ok : iu;

  bfsp_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(MAX_VERTICES * MAX_VERTICES)) u_weight (
    .clk(clk), .we(ld_ok), .waddr(w_waddr), .wdata(wz[WEIGHT_BITS-1:0]),
    .raddr(w_raddr), .rdata(w_dout)
  );

  // two copies of the distance store give the u and v reads in the same cycle
  bfsp_ram #(.WIDTH(DIST_W), .DEPTH(MAX_VERTICES)) u_dist_a (
    .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
    .raddr(da_raddr), .rdata(da_dout)
  );

  bfsp_ram #(.WIDTH(DIST_W), .DEPTH(MAX_VERTICES)) u_dist_b (
    .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
    .raddr(iv), .rdata(db_dout)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      vcount   <= COUNT_W'(1);
      src      <= '0;
      n_run    <= CW'(1);
      rnd      <= '0;
      iu       <= '0;
      iv       <= '0;
      ok       <= '0;
      s2_valid <= 1'b0;
      reached  <= '0;
      wq_en    <= 1'b0;
      cyc      <= 1'b0;
      ovalid   <= 1'b0;
      strobe   <= 1'b0;
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_VERTEX_COUNT:  vcount <= wr_data;
          REG_SOURCE_VERTEX: src    <= wr_data[IDX_W-1:0];
          default: ;
        endcase
      end

      strobe   <= 1'b0;
      ovalid   <= 1'b0;
      s2_valid <= 1'b0;
      wq_en    <= relax_w;
      wq_addr  <= s2_v;
      wq_data  <= cand;
      if (relax_w) begin
        reached[s2_v] <= 1'b1;
      end
      if (relax && s2_check) begin
        cyc <= 1'b1;
      end

      case (state)
        S_IDLE: begin
          if (run_go) begin
            n_run   <= CW'(n_sel);
            rnd     <= CW'(1);
            iu      <= '0;
            iv      <= '0;
            cyc     <= 1'b0;
            wq_en   <= 1'b0;
            reached <= '0;
            if (src_in) begin
              reached[IW'(src)] <= 1'b1;
            end
            state <= S_RELAX;
          end
        end
        S_RELAX: begin
          s2_valid <= 1'b1;
          s2_u     <= iu;
          s2_v     <= iv;
          s2_check <= check_issue;
          if (iv == last_idx) begin
            iv <= '0;
            if (iu == last_idx) begin
              iu <= '0;
              if (check_issue) begin
                state <= S_FLUSH;
              end else begin
                rnd <= rnd + CW'(1);
              end
            end else begin
              iu <= iu + IW'(1);
            end
          end else begin
            iv <= iv + IW'(1);
          end
        end
        S_FLUSH: begin
          ok    <= '0;
          state <= S_OUT;
        end
        S_OUT: begin
          if (cyc) begin
            strobe         <= 1'b1;
            vertex         <= '0;
            distance       <= '0;
            reachable      <= 1'b0;
            negative_cycle <= 1'b1;
            last           <= 1'b1;
            state          <= S_IDLE;
          end else begin
            ovalid <= 1'b1;
            oidx   <= ok;
            if (ok == last_idx) begin
              state <= S_OLAST;
            end else begin
              ok <= ok + IW'(1);
            end
          end
        end
        S_OLAST: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase

      if (ovalid) begin
        strobe         <= 1'b1;
        vertex         <= IDX_W'(oidx);
        reachable      <= reached[oidx];
        distance       <= reached[oidx] ? $signed(da_dout) : '0;
        negative_cycle <= 1'b0;
        last           <= (oidx == last_idx);
      end
    end
  end

  a_neg_is_last: assert property (@(posedge clk) disable iff (rst)
    strobe && negative_cycle |-> last && !reachable)
    else $error("negative-cycle beat not final");

  a_run_holds_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && kind |=> busy)
    else $error("run start did not raise busy");

  a_check_no_write: assert property (@(posedge clk) disable iff (rst)
    s2_valid && s2_check |-> !d_we)
    else $error("distance written during checking round");

  a_unreached_zero: assert property (@(posedge clk) disable iff (rst)
    strobe && !reachable |-> distance == '0)
    else $error("unreachable vertex with non-zero distance");

  a_no_beat_mid_run: assert property (@(posedge clk) disable iff (rst)
    state == S_RELAX |-> !strobe && !ovalid)
    else $error("result beat during relaxation");

endmodule

// ===== tb/bellman_ford_shortest_paths_tb.sv =====
// Testbench for the shortest-path engine: directed table, then random graphs checked beat by beat.
`timescale 1ns / 1ps

module bellman_ford_shortest_paths_tb;
  import bfsp_pkg::*;

  localparam int MAX_V          = MAX_VERTICES_DEF;
  localparam int WATCHDOG_LIMIT = 1_000_000;
  localparam logic KIND_EDGE    = 1'b0;
  localparam logic KIND_RUN     = 1'b1;

  typedef struct packed {
    logic [IDX_W-1:0]         vertex;
    logic signed [DIST_W-1:0] distance;
    logic                     reachable;
    logic                     negative_cycle;
    logic                     last;
  } path_result_t;

  typedef enum logic [1:0] {ST_CONFIG, ST_EDGE, ST_RUN} stim_op_t;

  typedef struct packed {
    stim_op_t                       op;
    logic [IDX_W-1:0]               a;
    logic [IDX_W-1:0]               b;
    logic signed [WEIGHT_IN_W-1:0]  val;
    logic                           typed;
    path_result_t                   res;
  } dir_row_t;

  localparam path_result_t NO_RES = '0;
  localparam path_result_t RES_ONE_REACHED =
    '{vertex: '0, distance: '0, reachable: 1'b1, negative_cycle: 1'b0, last: 1'b1};
  localparam path_result_t RES_ONE_UNREACHED =
    '{vertex: '0, distance: '0, reachable: 1'b0, negative_cycle: 1'b0, last: 1'b1};
  localparam path_result_t RES_NEG_CYCLE =
    '{vertex: '0, distance: '0, reachable: 1'b0, negative_cycle: 1'b1, last: 1'b1};

  localparam int DIR_ROWS = 26;
  dir_row_t dir_table [DIR_ROWS] = '{
    '{ST_EDGE,   6'd0,  6'd0,  16'sd0,  1'b0, NO_RES},
    '{ST_RUN,    6'd0,  6'd0,  16'sd0,  1'b1, RES_ONE_REACHED},
    '{ST_CONFIG, 6'(REG_VERTEX_COUNT),  6'd0, 16'sd0,  1'b0, NO_RES},
    '{ST_RUN,    6'd0,  6'd0,  16'sd0,  1'b1, RES_ONE_REACHED},
    '{ST_CONFIG, 6'(REG_SOURCE_VERTEX), 6'd0, 16'sd63, 1'b0, NO_RES},
    '{ST_RUN,    6'd0,  6'd0,  16'sd0,  1'b1, RES_ONE_UNREACHED},
    '{ST_CONFIG, 6'(REG_SOURCE_VERTEX), 6'd0, 16'sd0,  1'b0, NO_RES},
    '{ST_EDGE,   6'd0,  6'd0,  -16'sd1, 1'b0, NO_RES},
    '{ST_RUN,    6'd0,  6'd0,  16'sd0,  1'b1, RES_NEG_CYCLE},
    '{ST_EDGE,   6'd63, 6'd63, 16'sh7FFF, 1'b0, NO_RES},
    '{ST_EDGE,   6'd63, 6'd0,  16'sh8000, 1'b0, NO_RES},
    '{ST_EDGE,   6'd0,  6'd63, 16'sd1,  1'b0, NO_RES},
    '{ST_CONFIG, 6'(REG_VERTEX_COUNT),  6'd0, 16'sd2,  1'b0, NO_RES},
    '{ST_EDGE,   6'd0,  6'd0,  16'sd0,  1'b0, NO_RES},
    '{ST_EDGE,   6'd0,  6'd1,  16'sh7FFF, 1'b0, NO_RES},
    '{ST_EDGE,   6'd1,  6'd0,  16'sd0,  1'b0, NO_RES},
    '{ST_EDGE,   6'd1,  6'd1,  16'sd5,  1'b0, NO_RES},
    '{ST_RUN,    6'd0,  6'd0,  16'sd0,  1'b0, NO_RES},
    '{ST_EDGE,   6'd0,  6'd1,  16'sh8000, 1'b0, NO_RES},
    '{ST_EDGE,   6'd1,  6'd0,  16'sh7FFF, 1'b0, NO_RES},
    '{ST_RUN,    6'd0,  6'd0,  16'sd0,  1'b1, RES_NEG_CYCLE},
    '{ST_CONFIG, 6'(REG_SOURCE_VERTEX), 6'd0, 16'sd1,  1'b0, NO_RES},
    '{ST_EDGE,   6'd1,  6'd0,  16'sd0,  1'b0, NO_RES},
    '{ST_RUN,    6'd0,  6'd0,  16'sd0,  1'b0, NO_RES},
    '{ST_CONFIG, 6'(REG_SOURCE_VERTEX), 6'd0, 16'sd2,  1'b0, NO_RES},
    '{ST_RUN,    6'd0,  6'd0,  16'sd0,  1'b0, NO_RES}
  };

  logic                          clk;
  logic                          rst;
  logic                          start;
  logic                          busy;
  logic                          kind;
  logic [IDX_W-1:0]              row;
  logic [IDX_W-1:0]              col;
  logic signed [WEIGHT_IN_W-1:0] weight;
  logic                          wr_en;
  logic [REG_IDX_W-1:0]          wr_index;
  logic [COUNT_W-1:0]            wr_data;
  logic                          strobe;
  logic [IDX_W-1:0]              vertex;
  logic signed [DIST_W-1:0]      distance;
  logic                          reachable;
  logic                          negative_cycle;
  logic                          last;

  bellman_ford_shortest_paths dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .kind(kind), .row(row), .col(col), .weight(weight),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .strobe(strobe), .vertex(vertex), .distance(distance), .reachable(reachable),
    .negative_cycle(negative_cycle), .last(last)
  );

  // mirror of the weight store and registers
  logic signed [WEIGHT_IN_W-1:0] weight_mirror [0:MAX_V*MAX_V-1];
  bit                            weight_set    [0:MAX_V*MAX_V-1];
  logic [COUNT_W-1:0]            count_cfg;
  logic [IDX_W-1:0]              source_cfg;
  longint                        path_dist     [0:MAX_V-1];
  bit                            path_reached  [0:MAX_V-1];

  path_result_t path_q [$];
  path_result_t path_head;

  int fail_count;
  int items_sent;
  int run_count;
  int beats_checked;
  int neg_flags;
  int idle_cycles;
  int burst_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit relax_edge(input int u, input int v, input bit apply);
    longint w;
    longint cand;
    w = longint'(weight_mirror[u*MAX_V+v]);
    if (!path_reached[u]) return 1'b0;
    if (u != v && w == 0) return 1'b0;
    cand = path_dist[u] + w;
    if (cand > longint'(DIST_MAX)) cand = longint'(DIST_MAX);
    if (cand < longint'(DIST_MIN)) cand = longint'(DIST_MIN);
    if (path_reached[v] && cand >= path_dist[v]) return 1'b0;
    if (apply) begin
      path_dist[v] = cand;
      path_reached[v] = 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic void predict_paths();
    int n;
    bit cyc;
    path_result_t r;
    n = (count_cfg == 0) ? 1 : (count_cfg > MAX_V) ? MAX_V : int'(count_cfg);
    for (int k = 0; k < MAX_V; k++) begin
      path_dist[k] = 0;
      path_reached[k] = 1'b0;
    end
    if (source_cfg < n) path_reached[source_cfg] = 1'b1;
    for (int rnd = 1; rnd < n; rnd++)
      for (int u = 0; u < n; u++)
        for (int v = 0; v < n; v++)
          void'(relax_edge(u, v, 1'b1));
    cyc = 1'b0;
    for (int u = 0; u < n && !cyc; u++)
      for (int v = 0; v < n && !cyc; v++)
        if (relax_edge(u, v, 1'b0)) cyc = 1'b1;
    if (cyc) begin
      path_q.push_back(RES_NEG_CYCLE);
    end else begin
      for (int k = 0; k < n; k++) begin
        r.vertex = IDX_W'(k);
        r.distance = path_reached[k] ? DIST_W'(path_dist[k]) : '0;
        r.reachable = path_reached[k];
        r.negative_cycle = 1'b0;
        r.last = (k == n - 1);
        path_q.push_back(r);
      end
    end
  endfunction

  task automatic send_item(input logic k, input logic [IDX_W-1:0] r, input logic [IDX_W-1:0] c,
                           input logic signed [WEIGHT_IN_W-1:0] w, input bit predict);
    bit taken;
    start  <= 1'b1;
    kind   <= k;
    row    <= r;
    col    <= c;
    weight <= w;
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
    items_sent++;
    if (k == KIND_EDGE) begin
      weight_mirror[{r, c}] = w;
      weight_set[{r, c}] = 1'b1;
    end else begin
      run_count++;
      if (predict) predict_paths();
    end
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
    end else begin
      burst_left--;
    end
  endtask

  // registers change only once the engine has drained
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [COUNT_W-1:0] val);
    start <= 1'b0;
    while (path_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    do @(negedge clk); while (busy);
    @(posedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    @(posedge clk);
    wr_en <= 1'b0;
    if (idx == REG_VERTEX_COUNT) count_cfg = val;
    else source_cfg = val[IDX_W-1:0];
  endtask

  task automatic graph_run(input logic [COUNT_W-1:0] cnt, input logic [IDX_W-1:0] src,
                           input int neg_pct, input int zero_pct, input int rewrite_pct);
    int n;
    int sel;
    int mag;
    logic signed [WEIGHT_IN_W-1:0] w;
    n = (cnt == 0) ? 1 : (cnt > MAX_V) ? MAX_V : int'(cnt);
    write_reg(REG_VERTEX_COUNT, cnt);
    write_reg(REG_SOURCE_VERTEX, COUNT_W'(src));
    for (int r = 0; r < n; r++)
      for (int c = 0; c < n; c++)
        if (!weight_set[r*MAX_V+c] || $urandom_range(0, 99) < rewrite_pct) begin
          if ($urandom_range(0, 99) < 8)
            send_item(KIND_EDGE, IDX_W'($urandom), IDX_W'($urandom),
                      WEIGHT_IN_W'($urandom), 1'b1);
          sel = $urandom_range(0, 99);
          if (sel < zero_pct) begin
            w = '0;
          end else if (sel < zero_pct + neg_pct) begin
            mag = $urandom_range(1, 120);
            w = WEIGHT_IN_W'(-mag);
          end else if (sel < zero_pct + neg_pct + 5) begin
            w = WEIGHT_IN_W'($urandom);
          end else begin
            w = WEIGHT_IN_W'($urandom_range(1, 300));
          end
          send_item(KIND_EDGE, IDX_W'(r), IDX_W'(c), w, 1'b1);
        end
    send_item(KIND_RUN, IDX_W'($urandom), IDX_W'($urandom), WEIGHT_IN_W'($urandom), 1'b1);
    if ($urandom_range(0, 99) < 15)
      send_item(KIND_RUN, IDX_W'($urandom), IDX_W'($urandom), WEIGHT_IN_W'($urandom), 1'b1);
  endtask

  // result beats, sampled mid-cycle; watchdog last
  always @(negedge clk) begin
    if (!rst) begin
      if ((start && !busy) || strobe || wr_en) idle_cycles = 0;
      else idle_cycles++;
      if (strobe === 1'b1) begin
        if (path_q.size() == 0) begin
          $error("result beat with nothing pending: vertex %0d", vertex);
          fail_count++;
        end else begin
          path_head = path_q.pop_front();
          beats_checked++;
          if (negative_cycle === 1'b1) neg_flags++;
          if (vertex !== path_head.vertex) begin
            $error("vertex: expected %0d, got %0d", path_head.vertex, vertex);
            fail_count++;
          end
          if (distance !== path_head.distance) begin
            $error("distance: expected %0d, got %0d", path_head.distance, distance);
            fail_count++;
          end
          if (reachable !== path_head.reachable) begin
            $error("reachable: expected %0b, got %0b", path_head.reachable, reachable);
            fail_count++;
          end
          if (negative_cycle !== path_head.negative_cycle) begin
            $error("negative_cycle: expected %0b, got %0b", path_head.negative_cycle,
                   negative_cycle);
            fail_count++;
          end
          if (last !== path_head.last) begin
            $error("last: expected %0b, got %0b", path_head.last, last);
            fail_count++;
          end
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: %0d cycles without a beat", idle_cycles);
        $display("bellman_ford_shortest_paths verification failed");
        $finish;
      end
    end
  end

  initial begin
    int cnt;
    int src;
    int neg_pct;
    int rewrite_pct;
    rst      = 1'b1;
    start    = 1'b0;
    kind     = 1'b0;
    row      = '0;
    col      = '0;
    weight   = '0;
    wr_en    = 1'b0;
    wr_index = '0;
    wr_data  = '0;
    count_cfg  = 7'd1;
    source_cfg = '0;
    fail_count = 0;
    items_sent = 0;
    run_count = 0;
    beats_checked = 0;
    neg_flags = 0;
    idle_cycles = 0;
    burst_left = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_table[i]) begin
      case (dir_table[i].op)
        ST_CONFIG: write_reg(dir_table[i].a[REG_IDX_W-1:0], dir_table[i].val[COUNT_W-1:0]);
        ST_EDGE:   send_item(KIND_EDGE, dir_table[i].a, dir_table[i].b, dir_table[i].val, 1'b1);
        ST_RUN: begin
          if (dir_table[i].typed) path_q.push_back(dir_table[i].res);
          send_item(KIND_RUN, '0, '0, '0, !dir_table[i].typed);
        end
        default: ;
      endcase
    end

    while (items_sent < 500) begin
      case ($urandom_range(0, 19))
        0:                      cnt = $urandom_range(11, 16);
        1, 2, 3, 4, 5:          cnt = $urandom_range(6, 10);
        default:                cnt = $urandom_range(1, 5);
      endcase
      src = ($urandom_range(0, 99) < 85) ? $urandom_range(0, cnt - 1) : $urandom_range(0, 63);
      case ($urandom_range(0, 2))
        0:       neg_pct = 0;
        1:       neg_pct = 8;
        default: neg_pct = 25;
      endcase
      case ($urandom_range(0, 4))
        0:       rewrite_pct = 0;
        1:       rewrite_pct = 30;
        default: rewrite_pct = 100;
      endcase
      graph_run(COUNT_W'(cnt), IDX_W'(src), neg_pct, $urandom_range(20, 70), rewrite_pct);
    end

    start <= 1'b0;
    while (path_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("%0d items driven, %0d of them runs, vertex counts 0 to 16 and sources 0 to 63",
             items_sent, run_count);
    $display("%0d result beats checked, %0d negative-cycle flags among them",
             beats_checked, neg_flags);
    if (fail_count == 0) begin
      $display("bellman_ford_shortest_paths verification clean");
    end else begin
      $display("bellman_ford_shortest_paths verification failed");
    end
    $finish;
  end

endmodule
